// ===== design/kai_pkg.sv =====
// Shared types, codes and arithmetic helpers of the kinematic agent integrator.
// Used by the controller, the datapath and the top level; depends on nothing.
package kai_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int TS_FRAC       = 16;
   localparam int REQ_DATA_W    = 80;
   localparam int RSP_DATA_W    = 200;

   typedef enum logic [1:0] {
      FUNC_ADD_FORCE = 2'd0,
      FUNC_STEP      = 2'd1,
      FUNC_SET_POS   = 2'd2,
      FUNC_SET_DIR   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_MASS      = 2'd0,
      CSR_MAX_SPEED = 2'd1,
      CSR_MAX_FORCE = 2'd2,
      CSR_NEAR_ZERO = 2'd3
   } csr_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ITEM,
      OP_SQX,
      OP_SQY,
      OP_SUM,
      OP_SQRT_GO,
      OP_MUL_LIM,
      OP_DIV_CLIP,
      OP_DIV_ACC,
      OP_DIV_HEAD,
      OP_DIV_WB,
      OP_MUL_DT,
      OP_ADD_VEL,
      OP_ADD_POS,
      OP_LOAD_VEL,
      OP_STORE_VEL,
      OP_COMMIT_HEAD,
      OP_CLEAR_FORCE,
      OP_CAPTURE
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SUM,
      ST_ROOT,
      ST_ROOT_WAIT,
      ST_CMUL,
      ST_CDIV,
      ST_CWAIT,
      ST_ADIV,
      ST_AWAIT,
      ST_AMUL,
      ST_AADD,
      ST_LOADV,
      ST_STOREV,
      ST_PMUL,
      ST_PADD,
      ST_HDIV,
      ST_HWAIT,
      ST_HCOMMIT,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type op;
      logic   idx;      // vector component: 0 = x, 1 = y
      logic   lim_sel;  // 0 = max_force, 1 = max_speed
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic div_done;
      logic clip_need;
      logic head_ok;
      logic out_busy;
   } status_type;

   function automatic logic [31:0] mag32(logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   // sign a magnitude and saturate to 32-bit signed
   function automatic logic [31:0] sat_mag(logic neg, logic [31:0] m);
      logic big;
      big = m[31];
      if (big) begin
         return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return neg ? (32'd0 - m) : m;
   endfunction

   function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return s[31:0];
   endfunction

endpackage

// ===== design/kai_sqrt.sv =====
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// Depends on nothing; used by kai_dp.
module kai_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] rad_ff, rad_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[33:0], rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== design/kai_div.sv =====
// Iterative restoring divider, 64-bit dividend by 32-bit divisor, one quotient
// bit per cycle; quotients of 2^32 or more come back as all ones. Used by kai_dp.
module kai_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [31:0] quot
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, lo_ff[31]};
      if (start) begin
         den_in = den;
         cnt_in = '0;
         if (num[63:32] >= den) begin
            lo_in   = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = num[63:32];
            lo_in   = num[31:0];
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // shift the quotient bit in where the dividend bit leaves
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            lo_in  = {lo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            lo_in  = {lo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = lo_ff;

endmodule

// ===== design/kai_dp.sv =====
// Datapath: agent state, configuration registers, shared multiplier, square root
// and divider, result register. Depends on kai_pkg, kai_sqrt and kai_div.
module kai_dp #(
   parameter int FRAC_BITS = kai_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kai_pkg::cmd_type                    cmd,
   output kai_pkg::status_type                 status,
   input  logic [1:0]                          req_tuser,
   input  logic [kai_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_index,
   input  logic [30:0]                         csr_wdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [kai_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic [30:0] mass_ff, max_speed_ff, max_force_ff;
   logic [15:0] near_zero_ff;

   logic [31:0] force_ff [2];
   logic [31:0] vel_ff   [2];
   logic [31:0] pos_ff   [2];
   logic [31:0] head_ff  [2];
   logic [31:0] side_ff  [2];
   logic [31:0] w_ff     [2];
   logic [15:0] dt_ff;
   logic [63:0] mul_ff, mul_in;
   logic [63:0] sum_ff;
   logic        rsp_valid_ff;
   logic [kai_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [31:0] wmag, mul_a, mul_b, len, dv, lim32, mass_eff, quot;
   logic        wneg, sqrt_go, div_go, sqrt_done, div_done;
   logic [63:0] div_num;
   logic [31:0] div_den;
   logic [31:0] in_x, in_y;

   assign in_x = req_tdata[31:0];
   assign in_y = req_tdata[63:32];

   assign wmag     = kai_pkg::mag32(w_ff[cmd.idx]);
   assign wneg     = w_ff[cmd.idx][31];
   assign lim32    = {1'b0, (cmd.lim_sel ? max_speed_ff : max_force_ff)};
   assign mass_eff = (mass_ff == '0) ? 32'd1 : {1'b0, mass_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         kai_pkg::OP_SQX: begin
            mul_a = kai_pkg::mag32(w_ff[0]);
            mul_b = mul_a;
         end
         kai_pkg::OP_SQY: begin
            mul_a = kai_pkg::mag32(w_ff[1]);
            mul_b = mul_a;
         end
         kai_pkg::OP_MUL_LIM: begin
            mul_a = wmag;
            mul_b = lim32;
         end
         kai_pkg::OP_MUL_DT: begin
            mul_a = wmag;
            mul_b = {16'd0, dt_ff};
         end
         default: ;
      endcase
      mul_in = mul_a * mul_b;
   end

   assign sqrt_go = (cmd.op == kai_pkg::OP_SQRT_GO);
   assign div_go  = (cmd.op == kai_pkg::OP_DIV_CLIP) || (cmd.op == kai_pkg::OP_DIV_ACC) ||
                    (cmd.op == kai_pkg::OP_DIV_HEAD);
   assign div_num = (cmd.op == kai_pkg::OP_DIV_CLIP) ? mul_ff :
                    ({32'd0, wmag} << FRAC_BITS);
   assign div_den = (cmd.op == kai_pkg::OP_DIV_ACC) ? mass_eff : len;

   kai_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_go),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (len)
   );

   kai_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   // increment from a scaled product: magnitude stays below 2^31
   assign dv = wneg ? (32'd0 - 32'(mul_ff >> kai_pkg::TS_FRAC))
                    : 32'(mul_ff >> kai_pkg::TS_FRAC);

   always_comb begin
      status.sqrt_done = sqrt_done;
      status.div_done  = div_done;
      status.clip_need = len > lim32;
      status.head_ok   = (len != '0) && (len >= {16'd0, near_zero_ff});
      status.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff      <= 31'(64'd1 << FRAC_BITS);
         max_speed_ff <= 31'(64'd1 << FRAC_BITS);
         max_force_ff <= 31'(64'd1 << FRAC_BITS);
         near_zero_ff <= 16'd16;
      end else if (csr_wr_en) begin
         unique case (kai_pkg::csr_type'(csr_index))
            kai_pkg::CSR_MASS:      mass_ff      <= csr_wdata;
            kai_pkg::CSR_MAX_SPEED: max_speed_ff <= csr_wdata;
            kai_pkg::CSR_MAX_FORCE: max_force_ff <= csr_wdata;
            kai_pkg::CSR_NEAR_ZERO: near_zero_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (cmd.op == kai_pkg::OP_SQY) begin
         sum_ff <= mul_ff;
      end else if (cmd.op == kai_pkg::OP_SUM) begin
         sum_ff <= sum_ff + mul_ff;
      end
      if (cmd.op == kai_pkg::OP_CAPTURE) begin
         rsp_data_ff <= {side_ff[1][17:0], side_ff[0][17:0], head_ff[1][17:0],
                         head_ff[0][17:0], vel_ff[1], vel_ff[0], pos_ff[1], pos_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            force_ff[i] <= '0;
            vel_ff[i]   <= '0;
            pos_ff[i]   <= '0;
            head_ff[i]  <= '0;
            side_ff[i]  <= '0;
            w_ff[i]     <= '0;
         end
         dt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == kai_pkg::OP_CAPTURE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            kai_pkg::OP_ITEM: begin
               case (kai_pkg::func_type'(req_tuser))
                  kai_pkg::FUNC_ADD_FORCE: begin
                     force_ff[0] <= kai_pkg::sat_add(force_ff[0], in_x);
                     force_ff[1] <= kai_pkg::sat_add(force_ff[1], in_y);
                  end
                  kai_pkg::FUNC_STEP: begin
                     w_ff[0] <= force_ff[0];
                     w_ff[1] <= force_ff[1];
                     dt_ff   <= req_tdata[79:64];
                  end
                  kai_pkg::FUNC_SET_POS: begin
                     pos_ff[0] <= in_x;
                     pos_ff[1] <= in_y;
                  end
                  default: begin
                     head_ff[0] <= in_x;
                     head_ff[1] <= in_y;
                  end
               endcase
            end
            kai_pkg::OP_DIV_WB:   w_ff[cmd.idx] <= kai_pkg::sat_mag(wneg, quot);
            kai_pkg::OP_ADD_VEL:  vel_ff[cmd.idx] <= kai_pkg::sat_add(vel_ff[cmd.idx], dv);
            kai_pkg::OP_ADD_POS:  pos_ff[cmd.idx] <= kai_pkg::sat_add(pos_ff[cmd.idx], dv);
            kai_pkg::OP_LOAD_VEL: begin
               w_ff[0] <= vel_ff[0];
               w_ff[1] <= vel_ff[1];
            end
            kai_pkg::OP_STORE_VEL: begin
               vel_ff[0] <= w_ff[0];
               vel_ff[1] <= w_ff[1];
            end
            kai_pkg::OP_COMMIT_HEAD: begin
               head_ff[0] <= w_ff[0];
               head_ff[1] <= w_ff[1];
               side_ff[0] <= (w_ff[1] == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - w_ff[1]);
               side_ff[1] <= w_ff[0];
            end
            kai_pkg::OP_CLEAR_FORCE: begin
               force_ff[0] <= '0;
               force_ff[1] <= '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/kai_ctrl.sv =====
// Controller: sequences one item through the datapath (lengths, clips, divides,
// integration) and hands the result to the output register. Depends on kai_pkg.
module kai_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [1:0]          req_tuser,
   output logic                req_tready,
   input  kai_pkg::status_type status,
   output kai_pkg::cmd_type    cmd
);

   localparam logic [1:0] PASS_FORCE = 2'd0;
   localparam logic [1:0] PASS_VEL   = 2'd1;
   localparam logic [1:0] PASS_SPEED = 2'd2;

   kai_pkg::state_type state_ff, state_in;
   logic               idx_ff, idx_in;
   logic [1:0]         pass_ff, pass_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pass_in  = pass_ff;
      unique case (state_ff)
         kai_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               pass_in = PASS_FORCE;
               idx_in  = 1'b0;
               state_in = (kai_pkg::func_type'(req_tuser) == kai_pkg::FUNC_STEP) ?
                          kai_pkg::ST_SQX : kai_pkg::ST_DONE;
            end
         end
         kai_pkg::ST_SQX:  state_in = kai_pkg::ST_SQY;
         kai_pkg::ST_SQY:  state_in = kai_pkg::ST_SUM;
         kai_pkg::ST_SUM:  state_in = kai_pkg::ST_ROOT;
         kai_pkg::ST_ROOT: state_in = kai_pkg::ST_ROOT_WAIT;
         kai_pkg::ST_ROOT_WAIT: begin
            if (status.sqrt_done) begin
               idx_in = 1'b0;
               if (pass_ff == PASS_SPEED) begin
                  state_in = status.head_ok ? kai_pkg::ST_HDIV : kai_pkg::ST_CLEAR;
               end else if (status.clip_need) begin
                  state_in = kai_pkg::ST_CMUL;
               end else begin
                  state_in = (pass_ff == PASS_FORCE) ? kai_pkg::ST_ADIV : kai_pkg::ST_STOREV;
               end
            end
         end
         kai_pkg::ST_CMUL: state_in = kai_pkg::ST_CDIV;
         kai_pkg::ST_CDIV: state_in = kai_pkg::ST_CWAIT;
         kai_pkg::ST_CWAIT: begin
            if (status.div_done) begin
               if (!idx_ff) begin
                  idx_in   = 1'b1;
                  state_in = kai_pkg::ST_CMUL;
               end else begin
                  idx_in   = 1'b0;
                  state_in = (pass_ff == PASS_FORCE) ? kai_pkg::ST_ADIV : kai_pkg::ST_STOREV;
               end
            end
         end
         kai_pkg::ST_ADIV: state_in = kai_pkg::ST_AWAIT;
         kai_pkg::ST_AWAIT: begin
            if (status.div_done) state_in = kai_pkg::ST_AMUL;
         end
         kai_pkg::ST_AMUL: state_in = kai_pkg::ST_AADD;
         kai_pkg::ST_AADD: begin
            if (!idx_ff) begin
               idx_in   = 1'b1;
               state_in = kai_pkg::ST_ADIV;
            end else begin
               idx_in   = 1'b0;
               state_in = kai_pkg::ST_LOADV;
            end
         end
         kai_pkg::ST_LOADV: begin
            pass_in  = PASS_VEL;
            state_in = kai_pkg::ST_SQX;
         end
         kai_pkg::ST_STOREV: state_in = kai_pkg::ST_PMUL;
         kai_pkg::ST_PMUL:   state_in = kai_pkg::ST_PADD;
         kai_pkg::ST_PADD: begin
            if (!idx_ff) begin
               idx_in   = 1'b1;
               state_in = kai_pkg::ST_PMUL;
            end else begin
               idx_in   = 1'b0;
               pass_in  = PASS_SPEED;
               state_in = kai_pkg::ST_SQX;
            end
         end
         kai_pkg::ST_HDIV: state_in = kai_pkg::ST_HWAIT;
         kai_pkg::ST_HWAIT: begin
            if (status.div_done) begin
               if (!idx_ff) begin
                  idx_in   = 1'b1;
                  state_in = kai_pkg::ST_HDIV;
               end else begin
                  idx_in   = 1'b0;
                  state_in = kai_pkg::ST_HCOMMIT;
               end
            end
         end
         kai_pkg::ST_HCOMMIT: state_in = kai_pkg::ST_CLEAR;
         kai_pkg::ST_CLEAR:   state_in = kai_pkg::ST_DONE;
         kai_pkg::ST_DONE: begin
            if (!status.out_busy) state_in = kai_pkg::ST_IDLE;
         end
         default: state_in = kai_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op      = kai_pkg::OP_NONE;
      cmd.idx     = idx_ff;
      cmd.lim_sel = (pass_ff != PASS_FORCE);
      req_tready  = 1'b0;
      unique case (state_ff) inside
         kai_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = kai_pkg::OP_ITEM;
         end
         kai_pkg::ST_SQX:  cmd.op = kai_pkg::OP_SQX;
         kai_pkg::ST_SQY:  cmd.op = kai_pkg::OP_SQY;
         kai_pkg::ST_SUM:  cmd.op = kai_pkg::OP_SUM;
         kai_pkg::ST_ROOT: cmd.op = kai_pkg::OP_SQRT_GO;
         kai_pkg::ST_CMUL: cmd.op = kai_pkg::OP_MUL_LIM;
         kai_pkg::ST_CDIV: cmd.op = kai_pkg::OP_DIV_CLIP;
         kai_pkg::ST_ADIV: cmd.op = kai_pkg::OP_DIV_ACC;
         kai_pkg::ST_HDIV: cmd.op = kai_pkg::OP_DIV_HEAD;
         kai_pkg::ST_CWAIT, kai_pkg::ST_AWAIT, kai_pkg::ST_HWAIT: begin
            if (status.div_done) cmd.op = kai_pkg::OP_DIV_WB;
         end
         kai_pkg::ST_AMUL, kai_pkg::ST_PMUL: cmd.op = kai_pkg::OP_MUL_DT;
         kai_pkg::ST_AADD:    cmd.op = kai_pkg::OP_ADD_VEL;
         kai_pkg::ST_PADD:    cmd.op = kai_pkg::OP_ADD_POS;
         kai_pkg::ST_LOADV:   cmd.op = kai_pkg::OP_LOAD_VEL;
         kai_pkg::ST_STOREV:  cmd.op = kai_pkg::OP_STORE_VEL;
         kai_pkg::ST_HCOMMIT: cmd.op = kai_pkg::OP_COMMIT_HEAD;
         kai_pkg::ST_CLEAR:   cmd.op = kai_pkg::OP_CLEAR_FORCE;
         kai_pkg::ST_DONE: begin
            if (!status.out_busy) cmd.op = kai_pkg::OP_CAPTURE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kai_pkg::ST_IDLE;
         idx_ff   <= 1'b0;
         pass_ff  <= PASS_FORCE;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

// ===== design/kinematic_agent_integrator.sv =====
// Kinematic agent integrator: 2D point mass with force accumulation and Euler steps.
// Usage:
//   req_* carries one beat per operation: tuser selects add force, step, set
//   position or set direction; tdata holds the x/y pair and the step interval.
//   rsp_* returns one beat per request with position, velocity, heading and side.
//   csr_* writes mass, max_speed, max_force and near_zero; the user must write them
//   only while the block is idle, which the block itself does not enforce.
// Add force, set position and set direction go from idle straight to the done state,
//   which captures the result once the output register is free. A step runs three
//   vector lengths on the square root unit and up to eight divides on the divider,
//   all serialized through one shared multiplier; an acceleration divide that
//   overflows ends early. The block takes one item at a time: req_tready is high
//   only while idle.
// Reset (synchronous, active high) zeroes the state and loads the default
//   registers: mass 1.0, limits 1.0, near_zero 16.
// A stalled rsp beat holds in the output register; the next item may be taken,
//   and its result waits until the pending beat leaves.
// Depends on kai_pkg, kai_ctrl and kai_dp.
module kinematic_agent_integrator #(
   parameter int FRAC_BITS = kai_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [kai_pkg::REQ_DATA_W-1:0] req_tdata,   // val_x, val_y, time_step
   input  logic [1:0]                     req_tuser,   // func
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pos_x, pos_y, vel_x, vel_y, dir_x, dir_y, side_x, side_y
   output logic [kai_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [30:0]                    csr_wdata
);

   kai_pkg::cmd_type    cmd;
   kai_pkg::status_type status;

   kai_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kai_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== design/kai_checker.sv =====
// Port-level checks of the integrator's handshake timing, bound to the top level.
// Depends on kinematic_agent_integrator and kai_pkg.
module kai_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [kai_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // an accepted beat keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after accept");

   // a fresh result appears exactly as the block returns to idle
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result raised while block busy");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp beat changed");

endmodule

bind kinematic_agent_integrator kai_checker u_kai_checker (.*);

// ===== test/tb_kinematic_agent_integrator.sv =====
// Self-checking testbench for kinematic_agent_integrator: directed and random beats,
// checked against a fixed-point predictor of the agent state kept in this file.
// Depends on kai_pkg and the design files only.
module tb_kinematic_agent_integrator;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 700;

   typedef struct packed {
      logic [17:0] side_y;
      logic [17:0] side_x;
      logic [17:0] dir_y;
      logic [17:0] dir_x;
      logic [31:0] vel_y;
      logic [31:0] vel_x;
      logic [31:0] pos_y;
      logic [31:0] pos_x;
   } agent_state_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [kai_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0]                     req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [kai_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_wr_en;
   logic [1:0]                     csr_index;
   logic [30:0]                    csr_wdata;

   kinematic_agent_integrator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   agent_state_type expected_states[$];
   int              error_count;
   bit              idle_on;
   bit              hold_rsp;
   int              quiet_cycles;

   // predictor state
   longint unsigned mass_r, max_speed_r, max_force_r, near_zero_r;
   longint          frc[2], vel[2], pos[2], hdg[2], sdv[2];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   // sign(v) * trunc(|v| * num / den), saturated
   function automatic longint scale(longint v, longint unsigned num, longint unsigned den);
      longint unsigned m;
      m = magnitude(v) * num / den;
      if (m > 64'd2147483648) m = 64'd2147483648;
      return sat32((v < 0) ? -longint'(m) : longint'(m));
   endfunction

   function automatic longint unsigned vec_length(longint a, longint b);
      return isqrt(magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b));
   endfunction

   function automatic void integrate_step(longint unsigned dt);
      longint          f[2];
      longint unsigned len;
      longint unsigned m;
      longint          acc;
      f = frc;
      len = vec_length(f[0], f[1]);
      if (len > max_force_r) begin
         f[0] = scale(f[0], max_force_r, len);
         f[1] = scale(f[1], max_force_r, len);
      end
      m = (mass_r == 0) ? 1 : mass_r;
      for (int i = 0; i < 2; i++) begin
         acc = scale(f[i], 64'd1 << 16, m);
         vel[i] = sat32(vel[i] + scale(acc, dt, 64'd65536));
      end
      len = vec_length(vel[0], vel[1]);
      if (len > max_speed_r) begin
         vel[0] = scale(vel[0], max_speed_r, len);
         vel[1] = scale(vel[1], max_speed_r, len);
      end
      for (int i = 0; i < 2; i++) pos[i] = sat32(pos[i] + scale(vel[i], dt, 64'd65536));
      len = vec_length(vel[0], vel[1]);
      // hold heading at zero speed even with near_zero cleared
      if (len != 0 && len >= near_zero_r) begin
         hdg[0] = scale(vel[0], 64'd1 << 16, len);
         hdg[1] = scale(vel[1], 64'd1 << 16, len);
         sdv[0] = sat32(-hdg[1]);
         sdv[1] = hdg[0];
      end
      frc[0] = 0;
      frc[1] = 0;
   endfunction

   function automatic agent_state_type agent_apply(kai_pkg::func_type fn, logic [31:0] x,
                                                   logic [31:0] y, logic [15:0] dt);
      agent_state_type s;
      longint          vx;
      longint          vy;
      vx = longint'(signed'(x));
      vy = longint'(signed'(y));
      case (fn)
         kai_pkg::FUNC_ADD_FORCE: begin
            frc[0] = sat32(frc[0] + vx);
            frc[1] = sat32(frc[1] + vy);
         end
         kai_pkg::FUNC_STEP: integrate_step(longint'(dt));
         kai_pkg::FUNC_SET_POS: begin
            pos[0] = vx;
            pos[1] = vy;
         end
         default: begin
            hdg[0] = vx;
            hdg[1] = vy;
         end
      endcase
      s.pos_x  = pos[0][31:0];
      s.pos_y  = pos[1][31:0];
      s.vel_x  = vel[0][31:0];
      s.vel_y  = vel[1][31:0];
      s.dir_x  = hdg[0][17:0];
      s.dir_y  = hdg[1][17:0];
      s.side_x = sdv[0][17:0];
      s.side_y = sdv[1][17:0];
      return s;
   endfunction

   // Call at a rising edge; returns at the edge where the beat is taken.
   task automatic send_item(kai_pkg::func_type fn, logic [31:0] x, logic [31:0] y,
                            logic [15:0] dt);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {dt, y, x};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      expected_states.push_back(agent_apply(fn, x, y, dt));
   endtask

   task automatic write_reg(kai_pkg::csr_type idx, logic [30:0] value);
      req_tvalid <= 1'b0;
      while (expected_states.size() != 0) @(posedge clock);
      // the queue is empty, so every accepted step has returned its beat and the block is idle
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         kai_pkg::CSR_MASS:      mass_r      = 64'(value);
         kai_pkg::CSR_MAX_SPEED: max_speed_r = 64'(value);
         kai_pkg::CSR_MAX_FORCE: max_force_r = 64'(value);
         default:                near_zero_r = 64'(value[15:0]);
      endcase
   endtask

   task automatic set_limits(logic [30:0] m, logic [30:0] sp, logic [30:0] fo,
                             logic [15:0] nz);
      write_reg(kai_pkg::CSR_MASS, m);
      write_reg(kai_pkg::CSR_MAX_SPEED, sp);
      write_reg(kai_pkg::CSR_MAX_FORCE, fo);
      write_reg(kai_pkg::CSR_NEAR_ZERO, {15'd0, nz});
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // result side: check each beat, then decide the next ready level
   int stall_left;
   always @(posedge clock) begin
      agent_state_type act;
      agent_state_type exp_s;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            act = rsp_tdata;
            if (expected_states.size() == 0) begin
               $display("%0t: unexpected beat: expected none, actual %h", $time, act);
               error_count++;
            end else begin
               exp_s = expected_states.pop_front();
               check_field("pos_x", exp_s.pos_x, act.pos_x);
               check_field("pos_y", exp_s.pos_y, act.pos_y);
               check_field("vel_x", exp_s.vel_x, act.vel_x);
               check_field("vel_y", exp_s.vel_y, act.vel_y);
               check_field("dir_x", exp_s.dir_x, act.dir_x);
               check_field("dir_y", exp_s.dir_y, act.dir_y);
               check_field("side_x", exp_s.side_x, act.side_x);
               check_field("side_y", exp_s.side_y, act.side_y);
            end
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
         2:       return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
         default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
      endcase
   endfunction

   function automatic logic [15:0] rand_dt();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
   endfunction

   task automatic test_operations_directed();
      send_item(kai_pkg::FUNC_STEP, 32'd0, 32'd0, 16'hFFFF);   // zero speed keeps heading
      send_item(kai_pkg::FUNC_ADD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
      send_item(kai_pkg::FUNC_ADD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
      send_item(kai_pkg::FUNC_STEP, 32'd0, 32'd0, 16'hFFFF);
      send_item(kai_pkg::FUNC_SET_POS, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
      send_item(kai_pkg::FUNC_ADD_FORCE, 32'h0001_0000, 32'hFFFF_0000, 16'd0);
      send_item(kai_pkg::FUNC_STEP, 32'd0, 32'd0, 16'hFFFF);
      send_item(kai_pkg::FUNC_STEP, 32'd0, 32'd0, 16'd0);
      // side untouched
      send_item(kai_pkg::FUNC_SET_DIR, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
      send_item(kai_pkg::FUNC_SET_POS, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
      send_item(kai_pkg::FUNC_ADD_FORCE, 32'hFFFF_FFFF, 32'd1, 16'd0);
      send_item(kai_pkg::FUNC_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
   endtask

   task automatic test_register_extremes();
      // zero mass acts as one raw unit; wide-open limits
      set_limits(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd0);
      send_item(kai_pkg::FUNC_ADD_FORCE, 32'h0000_0100, 32'hFFFF_FF00, 16'd0);
      send_item(kai_pkg::FUNC_STEP, 32'd0, 32'd0, 16'hFFFF);
      send_item(kai_pkg::FUNC_STEP, 32'd0, 32'd0, 16'h8000);
      set_limits(31'h7FFF_FFFF, 31'd0, 31'd0, 16'hFFFF);
      send_item(kai_pkg::FUNC_ADD_FORCE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0);
      send_item(kai_pkg::FUNC_STEP, 32'd0, 32'd0, 16'hFFFF);
      set_limits(31'd1, 31'h0100_0000, 31'h7FFF_FFFF, 16'd0);
      send_item(kai_pkg::FUNC_ADD_FORCE, 32'h0000_0003, 32'h0000_0004, 16'd0);
      send_item(kai_pkg::FUNC_STEP, 32'd0, 32'd0, 16'hFFFF);
   endtask

   task automatic run_random(int count);
      logic [31:0] fx;
      logic [31:0] fy;
      for (int n = 0; n < count; n++) begin
         fx = rand_value();
         fy = rand_value();
         case ($urandom_range(0, 19))
            0, 1:                      send_item(kai_pkg::FUNC_SET_POS, fx, fy, rand_dt());
            2, 3, 4:                   send_item(kai_pkg::FUNC_SET_DIR, fx, fy, rand_dt());
            5, 6, 7, 8, 9, 10, 11, 12: send_item(kai_pkg::FUNC_ADD_FORCE, fx, fy, rand_dt());
            default:                   send_item(kai_pkg::FUNC_STEP, fx, fy, rand_dt());
         endcase
      end
   endtask

   task automatic test_random_settings();
      run_random(300);
      set_limits(31'h0000_8000, 31'h0040_0000, 31'h0020_0000, 16'd1000);
      run_random(300);
      set_limits(31'($urandom_range(1, 32'h7FFF_FFFF)), 31'h7FFF_FFFF, 31'($urandom),
                 16'($urandom));
      run_random(250);
      set_limits(31'h0080_0000, 31'h0000_4000, 31'h7FFF_FFFF, 16'd0);
      run_random(250);
      set_limits(31'h0000_0100, 31'h0100_0000, 31'h0004_0000, 16'hFFFF);
      run_random(250);
   endtask

   task automatic test_output_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      run_random(12);
   endtask

   task automatic test_no_idling();
      set_limits(31'h0001_0000, 31'h0010_0000, 31'h0008_0000, 16'd16);
      idle_on = 1'b0;
      run_random(470);
   endtask

   initial begin
      error_count = 0;
      idle_on     = 1'b1;
      hold_rsp    = 1'b0;
      quiet_cycles = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      mass_r = 64'd65536;
      max_speed_r = 64'd65536;
      max_force_r = 64'd65536;
      near_zero_r = 64'd16;
      for (int i = 0; i < 2; i++) begin
         frc[i] = 0; vel[i] = 0; pos[i] = 0; hdg[i] = 0; sdv[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_operations_directed();
      test_register_extremes();
      test_output_backpressure();
      test_random_settings();
      test_no_idling();

      req_tvalid <= 1'b0;
      while (expected_states.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
